@@ rtl/epdq_pkg.sv @@
// Package with the shared types, codes and reset defaults of the echo pulse distance qualifier.
package epdq_pkg;

    // Item kinds.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_POLL = 1'b1;

    // Internal result state codes.
    localparam logic [1:0] RS_NOT_READY = 2'd0;
    localparam logic [1:0] RS_READY     = 2'd1;
    localparam logic [1:0] RS_ERROR     = 2'd2;
    localparam logic [1:0] RS_UNUSED    = 2'd3;

    // Measure status codes reported on a poll.
    localparam logic [1:0] MS_NOT_READY = 2'd0;
    localparam logic [1:0] MS_READY     = 2'd1;
    localparam logic [1:0] MS_ERROR     = 2'd2;

    // Range status codes reported on a poll.
    localparam logic [1:0] RNG_IN    = 2'd0;
    localparam logic [1:0] RNG_OUT   = 2'd1;
    localparam logic [1:0] RNG_ERROR = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_WINDOW_LENGTH     = 3'd0;
    localparam logic [2:0] REG_START_TICK_FIRST  = 3'd1;
    localparam logic [2:0] REG_START_TICK_SECOND = 3'd2;
    localparam logic [2:0] REG_RETRY_LIMIT       = 3'd3;
    localparam logic [2:0] REG_RANGE_MAX         = 3'd4;
    localparam logic [2:0] REG_RANGE_MIN         = 3'd5;
    localparam logic [2:0] REG_HOLD_RELOAD       = 3'd6;
    localparam logic [2:0] REG_HOLD_THRESHOLD    = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    // Register defaults after reset.
    localparam logic [7:0] DEF_WINDOW_LENGTH     = 8'd128;
    localparam logic [7:0] DEF_START_TICK_FIRST  = 8'h01;
    localparam logic [7:0] DEF_START_TICK_SECOND = 8'h18;
    localparam logic [4:0] DEF_RETRY_LIMIT       = 5'd16;
    localparam logic [7:0] DEF_RANGE_MAX         = 8'h47;
    localparam logic [7:0] DEF_RANGE_MIN         = 8'h07;
    localparam logic [6:0] DEF_HOLD_RELOAD       = 7'd64;
    localparam logic [6:0] DEF_HOLD_THRESHOLD    = 7'd8;

    // Saturation value of the pulse length counter.
    localparam logic [7:0] PULSE_LEN_MAX = 8'hFF;

    // Input request payload.
    typedef struct packed {
        logic operation;
        logic echo_level;
    } in_item_t;

    // Result payload.
    typedef struct packed {
        logic       trigger_level;
        logic [1:0] measure_status;
        logic [7:0] distance_value;
        logic [1:0] range_status;
    } out_item_t;

    // Configuration register set.
    typedef struct packed {
        logic [7:0] window_length;
        logic [7:0] start_tick_first;
        logic [7:0] start_tick_second;
        logic [4:0] retry_limit;
        logic [7:0] range_max;
        logic [7:0] range_min;
        logic [6:0] hold_reload;
        logic [6:0] hold_threshold;
    } cfg_t;

endpackage

@@ rtl/echo_pulse_distance_qualifier.sv @@
// Top level of the echo pulse distance qualifier: request and result registers around the core.
//
// The block takes one request per clock cycle, a timer tick with an echo sample or a poll,
// and returns exactly one result for each. A request is held in an input register, the core
// updates its measurement state from it in one pass of short logic, and the result lands in
// an output register, so a result passes the input register and then the output register, and one
// request per cycle is sustained as long as results are taken. Only a stalled result register
// with a request already waiting holds off new requests. Configuration writes take effect at
// the next clock edge and are meant to happen while no request is in flight.
module echo_pulse_distance_qualifier
    import epdq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t      cfg;
    out_item_t step_result;

    logic      req_vld_reg;
    in_item_t  req_reg;
    logic      res_vld_reg;
    out_item_t res_reg;
    logic      advance;

    // The held request moves on when the result register is free or being emptied.
    assign advance  = req_vld_reg && (!res_vld_reg || out_ready);
    assign in_ready = !req_vld_reg || advance;

    epdq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    epdq_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (req_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // Request register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            req_vld_reg <= in_valid;
        end
    end

    // Request register payload.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            req_reg <= in_data;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= step_result;
        end
    end

    assign out_valid = res_vld_reg;
    assign out_data  = res_reg;

`ifndef SYNTH
    // A request that moves through the core always leaves a result behind.
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_vld_reg)
        else $error("processed request left no result");

    // A trigger result never carries poll status.
    a_trigger_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && res_reg.trigger_level |->
            res_reg.measure_status == MS_NOT_READY && res_reg.range_status == RNG_IN &&
            res_reg.distance_value == 8'd0)
        else $error("trigger result carried poll fields");

    // A waiting request is not dropped while the result side stalls.
    a_req_kept: assert property (@(posedge clk) disable iff (!rst_n)
        req_vld_reg && !advance |=> req_vld_reg)
        else $error("waiting request was lost");
`endif

endmodule

@@ rtl/epdq_cfg.sv @@
// Configuration register file of the echo pulse distance qualifier.
module epdq_cfg
    import epdq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    // Decode the index and write the addressed register, masked to its width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length     <= DEF_WINDOW_LENGTH;
            cfg_reg.start_tick_first  <= DEF_START_TICK_FIRST;
            cfg_reg.start_tick_second <= DEF_START_TICK_SECOND;
            cfg_reg.retry_limit       <= DEF_RETRY_LIMIT;
            cfg_reg.range_max         <= DEF_RANGE_MAX;
            cfg_reg.range_min         <= DEF_RANGE_MIN;
            cfg_reg.hold_reload       <= DEF_HOLD_RELOAD;
            cfg_reg.hold_threshold    <= DEF_HOLD_THRESHOLD;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_WINDOW_LENGTH:     cfg_reg.window_length     <= cfg_data;
                REG_START_TICK_FIRST:  cfg_reg.start_tick_first  <= cfg_data;
                REG_START_TICK_SECOND: cfg_reg.start_tick_second <= cfg_data;
                REG_RETRY_LIMIT:       cfg_reg.retry_limit       <= cfg_data[4:0];
                REG_RANGE_MAX:         cfg_reg.range_max         <= cfg_data;
                REG_RANGE_MIN:         cfg_reg.range_min         <= cfg_data;
                REG_HOLD_RELOAD:       cfg_reg.hold_reload       <= cfg_data[6:0];
                REG_HOLD_THRESHOLD:    cfg_reg.hold_threshold    <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/epdq_core.sv @@
// Measurement state and single-pass update logic of the echo pulse distance qualifier.
module epdq_core
    import epdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step_en,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    logic [7:0] tick_index_reg, tick_index_next;
    logic [7:0] pulse_length_reg, pulse_length_next;
    logic [7:0] pulse_start_reg, pulse_start_next;
    logic [4:0] bad_start_reg, bad_start_next;
    logic [1:0] result_state_reg, result_state_next;
    logic [7:0] held_distance_reg, held_distance_next;
    logic [6:0] hold_count_reg, hold_count_next;
    logic       in_range_reg, in_range_next;

    logic [7:0] tick_inc;
    logic       window_end;
    logic       good_start;
    logic [4:0] bad_start_inc;
    logic       dist_in_range;

    assign tick_inc      = tick_index_reg + 8'd1;
    assign window_end    = (tick_inc == cfg.window_length);
    assign good_start    = (pulse_start_reg == cfg.start_tick_first) ||
                           (pulse_start_reg == cfg.start_tick_second);
    assign bad_start_inc = (bad_start_reg < cfg.retry_limit) ? bad_start_reg + 5'd1
                                                             : bad_start_reg;
    assign dist_in_range = (held_distance_reg <= cfg.range_max) &&
                           (held_distance_reg >= cfg.range_min);

    // Next state and result for the request in hand.
    always_comb
    begin
        tick_index_next    = tick_index_reg;
        pulse_length_next  = pulse_length_reg;
        pulse_start_next   = pulse_start_reg;
        bad_start_next     = bad_start_reg;
        result_state_next  = result_state_reg;
        held_distance_next = held_distance_reg;
        hold_count_next    = hold_count_reg;
        in_range_next      = in_range_reg;
        result             = '0;

        if (item.operation == OP_TICK)
        begin
            tick_index_next = tick_inc;
            if (window_end)
            begin
                // Window over: no echo start in it is an error; a run in flight is dropped.
                if (pulse_start_reg == 8'd0)
                begin
                    result_state_next = RS_ERROR;
                end
                tick_index_next      = 8'd0;
                pulse_length_next    = 8'd0;
                pulse_start_next     = 8'd0;
                result.trigger_level = 1'b1;
            end
            else if (item.echo_level)
            begin
                // Echo high: note the start tick and count the run.
                if (pulse_length_reg == 8'd0)
                begin
                    pulse_start_next = tick_inc;
                end
                if (pulse_length_reg != PULSE_LEN_MAX)
                begin
                    pulse_length_next = pulse_length_reg + 8'd1;
                end
            end
            else
            begin
                // Echo low: judge a run that just ended.
                if (pulse_length_reg != 8'd0)
                begin
                    if (good_start)
                    begin
                        if (result_state_reg != RS_ERROR)
                        begin
                            result_state_next  = RS_READY;
                            held_distance_next = pulse_length_reg;
                        end
                        bad_start_next = 5'd0;
                    end
                    else
                    begin
                        bad_start_next = bad_start_inc;
                        if (bad_start_inc >= cfg.retry_limit)
                        begin
                            result_state_next = RS_ERROR;
                        end
                    end
                end
                pulse_length_next = 8'd0;
            end
        end
        else
        begin
            case (result_state_reg)
                RS_READY:
                begin
                    // Take the reading and run the hold-off debounce.
                    result_state_next = RS_NOT_READY;
                    if (dist_in_range)
                    begin
                        hold_count_next = cfg.hold_reload;
                    end
                    else if (hold_count_reg != 7'd0)
                    begin
                        hold_count_next = hold_count_reg - 7'd1;
                    end
                    in_range_next         = (hold_count_next > cfg.hold_threshold);
                    result.measure_status = MS_READY;
                    result.distance_value = held_distance_reg;
                    result.range_status   = in_range_next ? RNG_IN : RNG_OUT;
                end
                RS_NOT_READY:
                begin
                    result.measure_status = MS_NOT_READY;
                    result.range_status   = in_range_reg ? RNG_IN : RNG_OUT;
                end
                default:
                begin
                    result.measure_status = MS_ERROR;
                    result.range_status   = RNG_ERROR;
                end
            endcase
        end
    end

    // Control state, cleared by reset and updated once per request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_index_reg    <= 8'd0;
            pulse_length_reg  <= 8'd0;
            pulse_start_reg   <= 8'd0;
            bad_start_reg     <= 5'd0;
            result_state_reg  <= RS_NOT_READY;
            held_distance_reg <= 8'd0;
            hold_count_reg    <= 7'd0;
            in_range_reg      <= 1'b0;
        end
        else if (step_en)
        begin
            tick_index_reg    <= tick_index_next;
            pulse_length_reg  <= pulse_length_next;
            pulse_start_reg   <= pulse_start_next;
            bad_start_reg     <= bad_start_next;
            result_state_reg  <= result_state_next;
            held_distance_reg <= held_distance_next;
            hold_count_reg    <= hold_count_next;
            in_range_reg      <= in_range_next;
        end
    end

`ifndef SYNTH
    // The spare result state code is never reached.
    a_no_unused_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_state_reg != RS_UNUSED)
        else $error("result state took the unused code");

    // The error is sticky.
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        result_state_reg == RS_ERROR |=> result_state_reg == RS_ERROR)
        else $error("sticky error was cleared");

    // A window end restarts the tick counter and the pulse measurement.
    a_window_restart: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && item.operation == OP_TICK && window_end |=>
            tick_index_reg == 8'd0 && pulse_length_reg == 8'd0)
        else $error("window end did not restart the measurement");
`endif

endmodule

@@ test/echo_pulse_distance_qualifier_tb.sv @@
// Self-checking testbench for the echo pulse distance qualifier with its own behavior predictor.
`timescale 1ns / 1ps

module echo_pulse_distance_qualifier_tb;
    import epdq_pkg::*;

    localparam int          SETTLE_CYCLES   = 8;
    localparam int          HOLD_OFF_CYCLES = 60;
    localparam int          MAX_REPORTS     = 10;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int          DIRECTED_ROWS   = 24;

    // Expectations that can be read off directly.
    localparam out_item_t RES_NONE       = '{1'b0, MS_NOT_READY, 8'd0, RNG_IN};
    localparam out_item_t RES_WINDOW_END = '{1'b1, MS_NOT_READY, 8'd0, RNG_IN};
    localparam out_item_t RES_IDLE_POLL  = '{1'b0, MS_NOT_READY, 8'd0, RNG_OUT};
    localparam out_item_t RES_ERROR_POLL = '{1'b0, MS_ERROR, 8'd0, RNG_ERROR};

    typedef struct packed {
        logic      op;
        logic      echo;
        logic      fixed;
        out_item_t res;
    } dir_row_t;

    typedef struct {
        in_item_t  req;
        bit        fixed;
        out_item_t fixed_res;
    } req_row_t;

    // Directed rows, run with a six tick window, allowed starts at ticks 1 and 3.
    localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{OP_POLL, 1'b0, 1'b1, RES_IDLE_POLL},
        '{OP_TICK, 1'b1, 1'b0, RES_NONE},
        '{OP_TICK, 1'b1, 1'b0, RES_NONE},
        '{OP_TICK, 1'b0, 1'b0, RES_NONE},
        '{OP_POLL, 1'b0, 1'b0, RES_NONE},
        '{OP_POLL, 1'b1, 1'b0, RES_NONE},
        '{OP_TICK, 1'b1, 1'b0, RES_NONE},
        '{OP_TICK, 1'b0, 1'b0, RES_NONE},
        '{OP_TICK, 1'b0, 1'b1, RES_WINDOW_END},
        '{OP_TICK, 1'b0, 1'b0, RES_NONE},
        '{OP_TICK, 1'b0, 1'b0, RES_NONE},
        '{OP_TICK, 1'b1, 1'b0, RES_NONE},
        '{OP_TICK, 1'b1, 1'b0, RES_NONE},
        '{OP_TICK, 1'b1, 1'b0, RES_NONE},
        '{OP_TICK, 1'b1, 1'b1, RES_WINDOW_END},
        '{OP_POLL, 1'b0, 1'b0, RES_NONE},
        '{OP_TICK, 1'b1, 1'b0, RES_NONE},
        '{OP_TICK, 1'b0, 1'b0, RES_NONE},
        '{OP_POLL, 1'b0, 1'b0, RES_NONE},
        '{OP_TICK, 1'b0, 1'b0, RES_NONE},
        '{OP_TICK, 1'b1, 1'b0, RES_NONE},
        '{OP_TICK, 1'b1, 1'b0, RES_NONE},
        '{OP_TICK, 1'b0, 1'b1, RES_WINDOW_END},
        '{OP_POLL, 1'b0, 1'b0, RES_NONE}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_item_t              out_data;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predictor copy of the registers and the measurement state.
    cfg_t       cfg;
    logic [7:0] tick_idx;
    logic [7:0] pulse_len;
    logic [7:0] pulse_start;
    logic [4:0] bad_cnt;
    logic [1:0] res_state;
    logic [7:0] held_dist;
    logic [6:0] hold_cnt;
    logic       in_rng;

    req_row_t    request_q[$];
    out_item_t   expected_results[$];
    bit          echo_plan [0:255];
    int unsigned gen_bad;
    int unsigned fail_count;
    int unsigned requests_sent;
    int unsigned results_seen;
    int unsigned settings_count;
    int unsigned cycle_count;
    bit          hold_off_req;

    echo_pulse_distance_qualifier u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Predict the result of one request and advance the predicted state.
    function automatic out_item_t predict_result(in_item_t req);
        out_item_t r;
        r = RES_NONE;
        if (req.operation == OP_TICK)
        begin
            tick_idx = tick_idx + 8'd1;
            if (tick_idx == cfg.window_length)
            begin
                // Window end: a window that saw no echo start is an error.
                if (pulse_start == 8'd0)
                    res_state = RS_ERROR;
                tick_idx        = 8'd0;
                pulse_len       = 8'd0;
                pulse_start     = 8'd0;
                r.trigger_level = 1'b1;
            end
            else if (req.echo_level)
            begin
                if (pulse_len == 8'd0)
                    pulse_start = tick_idx;
                if (pulse_len != PULSE_LEN_MAX)
                    pulse_len = pulse_len + 8'd1;
            end
            else
            begin
                // Falling echo: judge the run by the tick at which it started.
                if (pulse_len != 8'd0)
                begin
                    if (pulse_start == cfg.start_tick_first ||
                        pulse_start == cfg.start_tick_second)
                    begin
                        if (res_state != RS_ERROR)
                        begin
                            res_state = RS_READY;
                            held_dist = pulse_len;
                        end
                        bad_cnt = 5'd0;
                    end
                    else
                    begin
                        if (bad_cnt < cfg.retry_limit)
                            bad_cnt = bad_cnt + 5'd1;
                        if (bad_cnt >= cfg.retry_limit)
                            res_state = RS_ERROR;
                    end
                end
                pulse_len = 8'd0;
            end
        end
        else if (res_state == RS_READY)
        begin
            // Poll with a fresh reading: run the hold-off debounce.
            res_state = RS_NOT_READY;
            if (held_dist <= cfg.range_max && held_dist >= cfg.range_min)
                hold_cnt = cfg.hold_reload;
            else if (hold_cnt != 7'd0)
                hold_cnt = hold_cnt - 7'd1;
            in_rng           = (hold_cnt > cfg.hold_threshold);
            r.measure_status = MS_READY;
            r.distance_value = held_dist;
            r.range_status   = in_rng ? RNG_IN : RNG_OUT;
        end
        else if (res_state == RS_NOT_READY)
        begin
            r.range_status = in_rng ? RNG_IN : RNG_OUT;
        end
        else
        begin
            r.measure_status = MS_ERROR;
            r.range_status   = RNG_ERROR;
        end
        return r;
    endfunction

    task automatic push_req(logic op, logic echo);
        req_row_t row;
        row.req       = '{op, echo};
        row.fixed     = 1'b0;
        row.fixed_res = RES_NONE;
        request_q.push_back(row);
    endtask

    task automatic push_fixed(logic op, logic echo, out_item_t res);
        req_row_t row;
        row.req       = '{op, echo};
        row.fixed     = 1'b1;
        row.fixed_res = res;
        request_q.push_back(row);
    endtask

    task automatic maybe_poll();
        if ($urandom_range(0, 5) == 0)
            push_req(OP_POLL, logic'($urandom_range(0, 1)));
    endtask

    // One register write per clock; the caller lowers the enable afterwards.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_WINDOW_LENGTH:     cfg.window_length     = val;
            REG_START_TICK_FIRST:  cfg.start_tick_first  = val;
            REG_START_TICK_SECOND: cfg.start_tick_second = val;
            REG_RETRY_LIMIT:       cfg.retry_limit       = val[4:0];
            REG_RANGE_MAX:         cfg.range_max         = val;
            REG_RANGE_MIN:         cfg.range_min         = val;
            REG_HOLD_RELOAD:       cfg.hold_reload       = val[6:0];
            REG_HOLD_THRESHOLD:    cfg.hold_threshold    = val[6:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic program_regs(logic [7:0] wl, logic [7:0] first, logic [7:0] second,
                                logic [7:0] retry, logic [7:0] rmax, logic [7:0] rmin,
                                logic [7:0] reload, logic [7:0] thr);
        write_reg(REG_WINDOW_LENGTH, wl);
        write_reg(REG_START_TICK_FIRST, first);
        write_reg(REG_START_TICK_SECOND, second);
        write_reg(REG_RETRY_LIMIT, retry);
        write_reg(REG_RANGE_MAX, rmax);
        write_reg(REG_RANGE_MIN, rmin);
        write_reg(REG_HOLD_RELOAD, reload);
        write_reg(REG_HOLD_THRESHOLD, thr);
        end_writes();
        settings_count++;
        gen_bad = {27'd0, bad_cnt};
    endtask

    // Offer queued requests in bursts with gaps; predict each one as it is accepted.
    task automatic send_requests();
        req_row_t row;
        int       burst;
        int       gap;
        while (request_q.size() > 0)
        begin
            burst = $urandom_range(1, 24);
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            while (burst > 0 && request_q.size() > 0)
            begin
                row = request_q.pop_front();
                @(negedge clk);
                in_valid <= 1'b1;
                in_data  <= row.req;
                do
                    @(posedge clk);
                while (!in_ready);
                requests_sent++;
                if (row.fixed)
                begin
                    void'(predict_result(row.req));
                    expected_results.push_back(row.fixed_res);
                end
                else
                begin
                    expected_results.push_back(predict_result(row.req));
                end
                burst--;
            end
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Send the queued requests, wait until every expected result has come back, then let the pipeline settle.
    task automatic drain();
        send_requests();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Choose an echo start tick at or after lo inside the current window.
    task automatic pick_start(int unsigned lo, int unsigned w, output int unsigned s,
                              output bit good);
        int unsigned cand [2];
        int unsigned n;
        n = 0;
        if (cfg.start_tick_first >= lo && cfg.start_tick_first <= w - 1)
        begin
            cand[n] = {24'd0, cfg.start_tick_first};
            n++;
        end
        if (cfg.start_tick_second >= lo && cfg.start_tick_second <= w - 1)
        begin
            cand[n] = {24'd0, cfg.start_tick_second};
            n++;
        end
        if (n > 0 && $urandom_range(0, 3) != 0)
            s = cand[$urandom_range(0, n - 1)];
        else
            s = $urandom_range(lo, w - 1);
        good = (s == cfg.start_tick_first || s == cfg.start_tick_second);
    endtask

    // Mark a high run from tick s; a bad run is pushed across the window end when
    // judging it would reach the retry limit.
    task automatic place_pulse(int unsigned s, int unsigned w, bit good,
                               output int unsigned e);
        int unsigned t;
        e = $urandom_range(s + 1, w);
        if (e < w && !good && gen_bad + 1 >= cfg.retry_limit)
            e = w;
        for (t = s; t < e && t < w; t++)
            echo_plan[t] = 1'b1;
        if (e < w)
            gen_bad = good ? 0 : gen_bad + 1;
    endtask

    // Queue one well-formed window: an echo start, maybe a second run, and random polls.
    task automatic queue_window();
        int unsigned w;
        int unsigned s;
        int unsigned e;
        int unsigned t;
        bit          good;
        w = {24'd0, cfg.window_length};
        for (t = 0; t < 256; t++)
            echo_plan[t] = 1'b0;
        pick_start(1, w, s, good);
        place_pulse(s, w, good, e);
        if (e + 3 <= w && $urandom_range(0, 2) == 0)
        begin
            pick_start(e + 1, w, s, good);
            place_pulse(s, w, good, e);
        end
        for (t = 1; t <= w; t++)
        begin
            maybe_poll();
            // The echo sample on the window's last tick is ignored by the block.
            push_req(OP_TICK, (t == w) ? logic'($urandom_range(0, 1)) : echo_plan[t]);
        end
    endtask

    task automatic run_windows(int n);
        repeat (n) queue_window();
        drain();
    endtask

    // Result sink: stall patterns of its own, plus one long hold-off on request.
    initial
    begin : result_sink
        int mode;
        int seg;
        int k;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                for (k = 0; k < HOLD_OFF_CYCLES; k++)
                begin
                    @(negedge clk);
                    out_ready <= 1'b0;
                end
                hold_off_req = 1'b0;
            end
            mode = $urandom_range(0, 2);
            seg  = $urandom_range(4, 40);
            for (k = 0; k < seg && !hold_off_req; k++)
            begin
                @(negedge clk);
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= logic'($urandom_range(0, 1));
                    default: out_ready <= ((k % 4) != 3);
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("ERROR: result %0d arrived with nothing expected: %p",
                             results_seen, out_data);
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_data.trigger_level !== want.trigger_level ||
                    out_data.measure_status !== want.measure_status ||
                    out_data.distance_value !== want.distance_value ||
                    out_data.range_status !== want.range_status)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"ERROR: result %0d expected trig=%0d ms=%0d dist=%0d rng=%0d,",
                                  " got trig=%0d ms=%0d dist=%0d rng=%0d"},
                                 results_seen, want.trigger_level, want.measure_status,
                                 want.distance_value, want.range_status,
                                 out_data.trigger_level, out_data.measure_status,
                                 out_data.distance_value, out_data.range_status);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results pending",
                     cycle_count, expected_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin : main_seq
        int i;
        int k;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        hold_off_req = 1'b0;
        fail_count     = 0;
        requests_sent  = 0;
        results_seen   = 0;
        settings_count = 0;
        cycle_count    = 0;
        gen_bad        = 0;
        cfg = '{DEF_WINDOW_LENGTH, DEF_START_TICK_FIRST, DEF_START_TICK_SECOND,
                DEF_RETRY_LIMIT, DEF_RANGE_MAX, DEF_RANGE_MIN, DEF_HOLD_RELOAD,
                DEF_HOLD_THRESHOLD};
        tick_idx    = 8'd0;
        pulse_len   = 8'd0;
        pulse_start = 8'd0;
        bad_cnt     = 5'd0;
        res_state   = RS_NOT_READY;
        held_dist   = 8'd0;
        hold_cnt    = 7'd0;
        in_rng      = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table on a short window.
        program_regs(8'd6, 8'd1, 8'd3, 8'd4, 8'd10, 8'd2, 8'd5, 8'd2);
        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (DIRECTED[i].fixed)
                push_fixed(DIRECTED[i].op, DIRECTED[i].echo, DIRECTED[i].res);
            else
                push_req(DIRECTED[i].op, DIRECTED[i].echo);
        end
        drain();

        // Moderate window, with the long result hold-off while requests keep coming.
        program_regs(8'd16, 8'd1, 8'd7, 8'd4, 8'd12, 8'd3, 8'd6, 8'd2);
        hold_off_req = 1'b1;
        run_windows(3);

        // Shortest window; masked writes give the top retry limit and hold reload and a zero hold threshold.
        program_regs(8'd2, 8'd1, 8'd255, 8'hFF, 8'd255, 8'd0, 8'hFF, 8'h80);
        run_windows(10);

        // Long echo: longest window, then shortened below the current tick so the
        // counter wraps and the pulse length saturates.
        program_regs(8'd255, 8'd1, 8'd200, 8'd31, 8'd255, 8'd0, 8'd100, 8'd50);
        for (k = 1; k <= 140; k++)
        begin
            push_req(OP_TICK, 1'b1);
        end
        drain();
        write_reg(REG_WINDOW_LENGTH, 8'd12);
        end_writes();
        for (k = 0; k < 128; k++)
        begin
            push_req(OP_TICK, (k < 120) ? 1'b1 : ((k == 127) ? logic'($urandom_range(0, 1))
                                                              : 1'b0));
        end
        push_req(OP_POLL, 1'b0);
        drain();

        program_regs(8'd10, 8'd2, 8'd9, 8'd3, 8'd8, 8'd2, 8'd3, 8'd1);
        run_windows(2);

        // Empty range and the smallest retry limit.
        program_regs(8'd24, 8'd255, 8'd20, 8'd1, 8'd0, 8'd255, 8'd0, 8'd127);
        run_windows(1);

        // Sticky error, by a bad start or by a window without echo, then noise.
        program_regs(8'd10, 8'd1, 8'd2, 8'h21, 8'd255, 8'd0, 8'd127, 8'd126);
        queue_window();
        push_req(OP_POLL, 1'b0);
        for (k = 1; k <= 10; k++)
        begin
            if ($urandom_range(0, 1) == 0 || k != 3)
                push_req(OP_TICK, (k == 10) ? logic'($urandom_range(0, 1)) : 1'b0);
            else
                push_req(OP_TICK, 1'b1);
        end
        push_fixed(OP_POLL, 1'b0, RES_ERROR_POLL);
        for (k = 0; k < 20; k++)
            push_req(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
        push_fixed(OP_POLL, 1'b1, RES_ERROR_POLL);
        drain();

        $display("Run summary: %0d requests, %0d results, %0d register settings.",
                 requests_sent, results_seen, settings_count);
        $display("Covered window extremes, masked writes, echo across window end, %s",
                 "saturated long echo after a counter wrap, and the sticky error.");
        if (fail_count == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/epdq_pkg.sv
rtl/epdq_cfg.sv
rtl/epdq_core.sv
rtl/echo_pulse_distance_qualifier.sv
test/echo_pulse_distance_qualifier_tb.sv
